// ===== design/status_frame_deframer_top_macros.svh =====
// Assertion helpers for the deframer core (sfd_core).
`ifndef STATUS_FRAME_DEFRAMER_TOP_MACROS_SVH
`define STATUS_FRAME_DEFRAMER_TOP_MACROS_SVH

// Check a condition at every rising clock edge outside reset.
`define SFD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies another in the same cycle.
`define SFD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies another in the next cycle.
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/sfd_pkg.sv =====
`timescale 1ns / 1ps

package sfd_pkg;

  localparam int CountW = 6;
  localparam int DefaultMaxFrameBytes = 32;
  localparam int MinFrameLen = 17;
  localparam int SumLen = 16;
  localparam int StageFirst = 2;
  localparam int StageDepth = 15;
  localparam int HeldWords = 6;
  localparam int CfgIndexW = 8;
  localparam logic [7:0] ResetMagic = 8'h5A;
  localparam logic [7:0] ResetVersion = 8'h01;
  localparam logic [CfgIndexW-1:0] CfgIdxMagic = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgIdxVersion = 8'd1;

  typedef enum logic [1:0] {
    StAccepted  = 2'd0,
    StTooShort  = 2'd1,
    StBadHeader = 2'd2,
    StBadSum    = 2'd3
  } status_t;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] frame_byte;
  } item_t;

  typedef struct packed {
    logic [7:0] magic;
    logic [7:0] version;
  } cfg_t;

  typedef struct packed {
    status_t            frame_status;
    logic               remote_low_power;
    logic        [7:0]  link_quality;
    logic        [15:0] battery_mv;
    logic signed [15:0] value_x;
    logic signed [15:0] value_y;
    logic signed [15:0] value_z;
    logic signed [15:0] value_h;
    logic        [15:0] test_flags;
  } result_t;

endpackage

// ===== design/status_frame_deframer_top.sv =====
`timescale 1ns / 1ps
// A result reaches m_tvalid once its last byte has passed the input register and been registered by the core.
// Throughput: one byte per cycle; set by the input register and the output register.
// A last byte waits only while the previous result has not been taken.
// Reset (rst, synchronous): clears frame state, held values and valid flags,
// loads magic 0x5A and version 0x01; staging bytes are not cleared.

module status_frame_deframer_top #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::DefaultMaxFrameBytes
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // frame_byte
  input  logic                          s_tlast,   // last_byte
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // frame_status, remote_low_power, link_quality, battery_mv,
  // value_x, value_y, value_z, value_h, test_flags, zero fill
  output logic [111:0]                  m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfd_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  sfd_pkg::cfg_t    cfg;
  sfd_pkg::item_t   s_item;
  sfd_pkg::item_t   core_item;
  logic             core_valid;
  logic             core_ready;
  sfd_pkg::result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic   <= sfd_pkg::ResetMagic;
      cfg.version <= sfd_pkg::ResetVersion;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == sfd_pkg::CfgIdxMagic) begin
        cfg.magic <= cfg_data;
      end else if (cfg_index == sfd_pkg::CfgIdxVersion) begin
        cfg.version <= cfg_data;
      end
    end
  end

  assign s_item.frame_byte = s_tdata;
  assign s_item.last_byte  = s_tlast;

  sfd_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (s_item),
    .out_valid (core_valid),
    .out_ready (core_ready),
    .out_item  (core_item)
  );

  sfd_core #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (core_valid),
    .item_ready (core_ready),
    .item       (core_item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {5'b0, res.test_flags, res.value_h, res.value_z, res.value_y,
                    res.value_x, res.battery_mv, res.link_quality,
                    res.remote_low_power, res.frame_status};

endmodule

// ===== design/sfd_in_reg.sv =====
`timescale 1ns / 1ps

module sfd_in_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  sfd_pkg::item_t in_item,
  output logic          out_valid,
  input  logic          out_ready,
  output sfd_pkg::item_t out_item
);

  logic          valid;
  sfd_pkg::item_t item;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== design/sfd_core.sv =====
`timescale 1ns / 1ps
`include "status_frame_deframer_top_macros.svh"

module sfd_core #(
  parameter int MAX_FRAME_BYTES = sfd_pkg::DefaultMaxFrameBytes
) (
  input  logic            clk,
  input  logic            rst,
  input  sfd_pkg::cfg_t   cfg,
  input  logic            item_valid,
  output logic            item_ready,
  input  sfd_pkg::item_t  item,
  output logic            res_valid,
  input  logic            res_ready,
  output sfd_pkg::result_t res
);

  localparam int CW = sfd_pkg::CountW;
  localparam logic [CW:0] MaxLen = (CW+1)'(MAX_FRAME_BYTES);

  logic [CW-1:0]    byte_count;
  logic [7:0]       running_sum;
  logic             header_good;
  logic [7:0]       staged_bytes [sfd_pkg::StageDepth];
  logic             held_low_power;
  logic [7:0]       held_quality;
  logic [15:0]      held_words [sfd_pkg::HeldWords];
  logic             out_valid;
  sfd_pkg::status_t status;

  logic             res_free;
  logic             fire;
  logic [7:0]       b;
  logic [CW:0]      len_raw;
  logic [CW-1:0]    byte_count_next;
  logic [7:0]       running_sum_next;
  logic             header_good_next;
  logic [7:0]       sum_byte;
  sfd_pkg::status_t status_next;

  assign res_free   = !out_valid || res_ready;
  assign item_ready = !item.last_byte || res_free;
  assign fire       = item_valid && item_ready;
  assign b          = item.frame_byte;

  always_comb begin
    len_raw = {1'b0, byte_count} + (CW+1)'(1);
    if (len_raw > MaxLen) begin
      byte_count_next = MaxLen[CW-1:0];
    end else begin
      byte_count_next = len_raw[CW-1:0];
    end
    if (byte_count < CW'(sfd_pkg::SumLen)) begin
      running_sum_next = running_sum + b;
    end else begin
      running_sum_next = running_sum;
    end
    header_good_next = header_good;
    if (byte_count == CW'(0) && b != cfg.magic) begin
      header_good_next = 1'b0;
    end
    if (byte_count == CW'(1) && b != cfg.version) begin
      header_good_next = 1'b0;
    end
    if (byte_count == CW'(sfd_pkg::StageFirst + sfd_pkg::StageDepth - 1)) begin
      sum_byte = b;
    end else begin
      sum_byte = staged_bytes[sfd_pkg::StageDepth-1];
    end
    priority if (len_raw < (CW+1)'(sfd_pkg::MinFrameLen)) begin
      status_next = sfd_pkg::StTooShort;
    end else if (!header_good_next) begin
      status_next = sfd_pkg::StBadHeader;
    end else if (sum_byte != running_sum_next) begin
      status_next = sfd_pkg::StBadSum;
    end else begin
      status_next = sfd_pkg::StAccepted;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      running_sum    <= '0;
      header_good    <= 1'b1;
      held_low_power <= 1'b0;
      held_quality   <= '0;
      for (int k = 0; k < sfd_pkg::HeldWords; k++) begin
        held_words[k] <= '0;
      end
      out_valid <= 1'b0;
      status    <= sfd_pkg::StAccepted;
    end else begin
      if (res_ready) begin
        out_valid <= 1'b0;
      end
      if (fire) begin
        if (item.last_byte) begin
          byte_count  <= '0;
          running_sum <= '0;
          header_good <= 1'b1;
          out_valid   <= 1'b1;
          status      <= status_next;
          if (status_next == sfd_pkg::StAccepted) begin
            held_low_power <= staged_bytes[0][0];
            held_quality   <= staged_bytes[1];
            for (int k = 0; k < sfd_pkg::HeldWords; k++) begin
              held_words[k] <= {staged_bytes[2*k+3], staged_bytes[2*k+2]};
            end
          end
        end else begin
          byte_count  <= byte_count_next;
          running_sum <= running_sum_next;
          header_good <= header_good_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < sfd_pkg::StageDepth; i++) begin
      if (fire && byte_count == CW'(i + sfd_pkg::StageFirst)) begin
        staged_bytes[i] <= b;
      end
    end
  end

  assign res_valid            = out_valid;
  assign res.frame_status     = status;
  assign res.remote_low_power = held_low_power;
  assign res.link_quality     = held_quality;
  assign res.battery_mv       = held_words[0];
  assign res.value_x          = held_words[1];
  assign res.value_y          = held_words[2];
  assign res.value_z          = held_words[3];
  assign res.value_h          = held_words[4];
  assign res.test_flags       = held_words[5];

  `SFD_ASSERT(a_count_bound, clk, rst, {1'b0, byte_count} <= MaxLen, "byte count past limit")
  `SFD_ASSERT_NEXT(a_last_gives_result, clk, rst, fire && item.last_byte, out_valid, "no result after last byte")
  `SFD_ASSERT_NEXT(a_last_clears_count, clk, rst, fire && item.last_byte, byte_count == '0 && header_good, "frame state not cleared")
  `SFD_ASSERT_IMPL(a_last_waits, clk, rst, item_valid && item.last_byte && out_valid && !res_ready, !fire, "result overwritten")

endmodule

// ===== test/status_frame_deframer_top_tb.sv =====
`timescale 1ns / 1ps

module status_frame_deframer_top_tb;
  import sfd_pkg::*;

  localparam int MaxBytes = DefaultMaxFrameBytes;
  localparam int PhaseItems = 117;
  localparam int NumPhases = 6;
  localparam int DrainCycles = 8;
  localparam int RxStallCycles = 300;
  localparam int WatchdogLimit = 3000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    status_t    st;
  } dir_row_t;

  localparam dir_row_t DirRows [21] = '{
    '{8'hFF, 1'b1, 1'b1, StTooShort},
    '{8'h5A, 1'b0, 1'b0, StAccepted},
    '{8'h00, 1'b0, 1'b0, StAccepted},
    '{8'hFF, 1'b0, 1'b0, StAccepted},
    '{8'hFF, 1'b0, 1'b0, StAccepted},
    '{8'hFF, 1'b0, 1'b0, StAccepted},
    '{8'hFF, 1'b0, 1'b0, StAccepted},
    '{8'h00, 1'b0, 1'b0, StAccepted},
    '{8'h80, 1'b0, 1'b0, StAccepted},
    '{8'hFF, 1'b0, 1'b0, StAccepted},
    '{8'h7F, 1'b0, 1'b0, StAccepted},
    '{8'h00, 1'b0, 1'b0, StAccepted},
    '{8'h00, 1'b0, 1'b0, StAccepted},
    '{8'hFF, 1'b0, 1'b0, StAccepted},
    '{8'hFF, 1'b0, 1'b0, StAccepted},
    '{8'h00, 1'b0, 1'b0, StAccepted},
    '{8'h00, 1'b0, 1'b0, StAccepted},
    '{8'h53, 1'b1, 1'b1, StBadHeader},
    '{8'h5A, 1'b0, 1'b0, StAccepted},
    '{8'h01, 1'b0, 1'b0, StAccepted},
    '{8'h00, 1'b1, 1'b1, StTooShort}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [111:0]         m_tdata;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIndexW-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  int error_count = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 13;
  int rx_idle_pct = 85;
  bit stall_request = 1'b0;
  bit stall_done = 1'b0;
  int stall_left = 0;

  result_t status_reports [$];

  logic [7:0]  cur_magic;
  logic [7:0]  cur_version;
  int          frm_count;
  logic [7:0]  frm_sum;
  logic        frm_hdr_ok;
  logic [7:0]  stage_bytes [StageDepth];
  logic        held_lp;
  logic [7:0]  held_q;
  logic [15:0] held_w [HeldWords];

  status_frame_deframer_top #(
    .MAX_FRAME_BYTES(MaxBytes)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic reset_model();
    int k;
    cur_magic = ResetMagic;
    cur_version = ResetVersion;
    frm_count = 0;
    frm_sum = '0;
    frm_hdr_ok = 1'b1;
    for (k = 0; k < StageDepth; k++) stage_bytes[k] = '0;
    held_lp = 1'b0;
    held_q = '0;
    for (k = 0; k < HeldWords; k++) held_w[k] = '0;
  endtask

  function automatic bit deframe_byte(input logic [7:0] b, input logic lb, output result_t r);
    int pos;
    int len;
    int k;
    status_t st;
    pos = frm_count;
    r = '0;
    if (pos < SumLen) frm_sum = frm_sum + b;
    if (pos == 0 && b != cur_magic) frm_hdr_ok = 1'b0;
    if (pos == 1 && b != cur_version) frm_hdr_ok = 1'b0;
    if (pos >= StageFirst && pos < StageFirst + StageDepth) stage_bytes[pos - StageFirst] = b;
    len = (pos + 1 > MaxBytes) ? MaxBytes : pos + 1;
    frm_count = len;
    if (!lb) return 1'b0;
    if (len < MinFrameLen) st = StTooShort;
    else if (!frm_hdr_ok) st = StBadHeader;
    else if (stage_bytes[StageDepth-1] != frm_sum) st = StBadSum;
    else st = StAccepted;
    if (st == StAccepted) begin
      held_lp = stage_bytes[0][0];
      held_q = stage_bytes[1];
      for (k = 0; k < HeldWords; k++) held_w[k] = {stage_bytes[2*k+3], stage_bytes[2*k+2]};
    end
    r.frame_status = st;
    r.remote_low_power = held_lp;
    r.link_quality = held_q;
    r.battery_mv = held_w[0];
    r.value_x = held_w[1];
    r.value_y = held_w[2];
    r.value_z = held_w[3];
    r.value_h = held_w[4];
    r.test_flags = held_w[5];
    frm_count = 0;
    frm_sum = '0;
    frm_hdr_ok = 1'b1;
    return 1'b1;
  endfunction

  function automatic result_t unpack_result(input logic [111:0] d);
    result_t r;
    r.frame_status = status_t'(d[1:0]);
    r.remote_low_power = d[2];
    r.link_quality = d[10:3];
    r.battery_mv = d[26:11];
    r.value_x = d[42:27];
    r.value_y = d[58:43];
    r.value_z = d[74:59];
    r.value_h = d[90:75];
    r.test_flags = d[106:91];
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] e, input logic [15:0] a);
    if (e !== a) begin
      $error("%s: expected %h, got %h", name, e, a);
      error_count++;
    end
  endtask

  task automatic compare_result(input result_t e, input result_t a);
    check_field("frame_status", 16'(e.frame_status), 16'(a.frame_status));
    check_field("remote_low_power", 16'(e.remote_low_power), 16'(a.remote_low_power));
    check_field("link_quality", 16'(e.link_quality), 16'(a.link_quality));
    check_field("battery_mv", e.battery_mv, a.battery_mv);
    check_field("value_x", e.value_x, a.value_x);
    check_field("value_y", e.value_y, a.value_y);
    check_field("value_z", e.value_z, a.value_z);
    check_field("value_h", e.value_h, a.value_h);
    check_field("test_flags", e.test_flags, a.test_flags);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic lb, input logic typed,
                           input status_t typed_st);
    result_t r;
    bit has;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= lb;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    has = deframe_byte(b, lb, r);
    if (has) begin
      if (typed) begin
        r = '0;
        r.frame_status = typed_st;
      end
      status_reports.push_back(r);
    end
    bytes_sent++;
  endtask

  task automatic send_frame();
    logic [7:0] fb [$];
    logic [7:0] sum;
    int pick;
    int len;
    int i;
    pick = $urandom_range(0, 99);
    fb = {};
    if (pick < 75) begin
      fb.push_back(cur_magic);
      fb.push_back(cur_version);
      for (i = 2; i < SumLen; i++) fb.push_back(rand_byte());
      if (pick >= 55 && pick < 65) begin
        i = $urandom_range(0, 1);
        fb[i] = fb[i] ^ 8'($urandom_range(1, 255));
      end
      sum = '0;
      for (i = 0; i < SumLen; i++) sum = sum + fb[i];
      if (pick >= 65) sum = sum ^ 8'($urandom_range(1, 255));
      fb.push_back(sum);
      if (pick >= 45 && pick < 55) repeat ($urandom_range(1, 23)) fb.push_back(rand_byte());
    end else begin
      len = (pick < 88) ? $urandom_range(1, MinFrameLen - 1) : $urandom_range(1, 40);
      repeat (len) fb.push_back(rand_byte());
    end
    for (i = 0; i < fb.size(); i++) send_byte(fb[i], i == fb.size() - 1, 1'b0, StAccepted);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CfgIdxMagic) cur_magic = val;
    else if (idx == CfgIdxVersion) cur_version = val;
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (status_reports.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (status_reports.size() == 0) begin
          $error("result with nothing pending: %h", m_tdata);
          error_count++;
        end else begin
          compare_result(status_reports.pop_front(), unpack_result(m_tdata));
        end
      end
      if (stall_request && !stall_done) begin
        stall_done <= 1'b1;
        stall_left <= RxStallCycles;
        m_tready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [7:0] magic_val;
    logic [7:0] version_val;
    logic [CfgIndexW-1:0] spare_idx;
    int phase;
    int phase_start;
    int i;
    reset_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < $size(DirRows); i++) begin
      send_byte(DirRows[i].data, DirRows[i].last, DirRows[i].typed, DirRows[i].st);
    end

    for (phase = 0; phase < NumPhases; phase++) begin
      wait_idle();
      magic_val = 8'($urandom_range(0, 255));
      version_val = 8'($urandom_range(0, 255));
      spare_idx = CfgIndexW'($urandom_range(2, 255));
      case (phase)
        0: begin
          magic_val = 8'h00;
          version_val = 8'hFF;
          spare_idx = 8'hFF;
        end
        1: begin
          magic_val = 8'hFF;
          version_val = 8'h00;
          spare_idx = 8'h02;
        end
        3: begin
          magic_val = ResetMagic;
          version_val = ResetVersion;
        end
        default: ;
      endcase
      write_reg(CfgIdxMagic, magic_val);
      write_reg(CfgIdxVersion, version_val);
      write_reg(spare_idx, 8'($urandom_range(0, 255)));
      cfg_valid <= 1'b0;

      case (phase / 2)
        0: begin
          tx_idle_pct = 13;
          rx_idle_pct <= 85;
        end
        1: begin
          tx_idle_pct = 85;
          rx_idle_pct <= 13;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct <= 0;
        end
      endcase
      // hold off the output while the input is driven with no idle gaps
      if (phase == 4) stall_request <= 1'b1;

      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseItems) send_frame();
    end

    wait_idle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sfd_pkg.sv
design/sfd_in_reg.sv
design/sfd_core.sv
design/status_frame_deframer_top.sv
test/status_frame_deframer_top_tb.sv
